// ----- src/jsf_pkg.sv -----
// Shared types and character codes for the JSON object stream framer.
// No dependencies; imported by every module of the framer.
`default_nettype none

package jsf_pkg;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  // one text byte as it moves from the input register to the scanner
  typedef struct packed {
    logic [7:0] text;
    logic       chunk_end;
  } jsf_item_t;

endpackage

`default_nettype wire

// ----- src/json_object_stream_framer_unit.sv -----
// An accepted byte reaches its result item via the input register, then the result register.
// One byte per cycle unless out_stall holds; the single scan stage updates all framing state.
// Bytes outside an object are consumed and give no result item.
// Reset (synchronous, rst_n low) clears both valid flags, the three framing flags and the
// brace balance.
// Depends on jsf_pkg, jsf_in_stage and jsf_scan.
`default_nettype none

module json_object_stream_framer_unit
  import jsf_pkg::*;
#(
  parameter int BALANCE_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_chunk_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_object_end
);

  logic      item_valid;
  jsf_item_t item;
  logic      take;

  jsf_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_chunk_end (in_chunk_end),
    .take         (take),
    .item_valid   (item_valid),
    .item         (item)
  );

  jsf_scan #(
    .BALANCE_BITS (BALANCE_BITS)
  ) u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item_valid),
    .item           (item),
    .take           (take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_object_end (out_object_end)
  );

endmodule

`default_nettype wire

// ----- src/jsf_in_stage.sv -----
// Input register of the framer: holds one accepted byte until the scanner takes it.
// Depends on jsf_pkg for the item type.
`default_nettype none

module jsf_in_stage
  import jsf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_chunk_end,
  input  wire logic       take,
  output logic            item_valid,
  output jsf_item_t       item
);

  logic      valid_r;
  jsf_item_t item_r;
  logic      load;

  // refill whenever the slot is empty or its item moves on this cycle
  assign load     = !valid_r || take;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r.text      <= in_byte;
      item_r.chunk_end <= in_chunk_end;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ----- src/jsf_scan.sv -----
// Framing state (object, string, escape flags and brace balance) and the result register.
// Depends on jsf_pkg for character codes and the item type.
`default_nettype none

module jsf_scan
  import jsf_pkg::*;
#(
  parameter int BALANCE_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_valid,
  input  wire jsf_item_t  item,
  output logic            take,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_object_end
);

  logic                    object_open_r, object_open_nxt;
  logic                    inside_string_r, inside_string_nxt;
  logic                    backslash_armed_r, backslash_armed_nxt;
  logic [BALANCE_BITS-1:0] brace_balance_r, brace_balance_nxt;
  logic                    out_valid_r;
  logic [7:0]              out_byte_r;
  logic                    out_object_end_r;

  logic                    is_lbrace, is_rbrace, is_quote, is_bslash;
  logic [BALANCE_BITS-1:0] balance_dec;
  logic                    closes, emit, step;

  assign take = !out_valid_r || !out_stall;
  assign step = item_valid && take;

  always_comb begin
    is_lbrace   = (item.text == CH_LBRACE);
    is_rbrace   = (item.text == CH_RBRACE);
    is_quote    = (item.text == CH_QUOTE);
    is_bslash   = (item.text == CH_BSLASH);
    balance_dec = brace_balance_r - {{(BALANCE_BITS-1){1'b0}}, 1'b1};
    closes      = is_rbrace && !inside_string_r && (balance_dec == '0);

    object_open_nxt   = object_open_r;
    inside_string_nxt = inside_string_r;
    brace_balance_nxt = brace_balance_r;
    if (is_lbrace && !inside_string_r) begin
      object_open_nxt   = 1'b1;
      brace_balance_nxt = brace_balance_r + {{(BALANCE_BITS-1){1'b0}}, 1'b1};
    end else if (is_rbrace && !inside_string_r) begin
      brace_balance_nxt = balance_dec;
      if (closes) begin
        object_open_nxt = 1'b0;
      end
    end else if (is_quote && !backslash_armed_r) begin
      inside_string_nxt = !inside_string_r;
    end
    // an escape never reaches across a chunk boundary
    backslash_armed_nxt = is_bslash && !item.chunk_end;
    emit                = closes || object_open_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      object_open_r     <= 1'b0;
      inside_string_r   <= 1'b0;
      backslash_armed_r <= 1'b0;
      brace_balance_r   <= '0;
    end else if (step) begin
      object_open_r     <= object_open_nxt;
      inside_string_r   <= inside_string_nxt;
      backslash_armed_r <= backslash_armed_nxt;
      brace_balance_r   <= brace_balance_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= item_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte_r       <= item.text;
      out_object_end_r <= closes;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_object_end = out_object_end_r;

endmodule

`default_nettype wire
